// ===== rtl/bounded_list_insert_delete_assert.svh =====
// Assertion macros used by the checker file of the bounded list block.
// Each macro expands to one labeled concurrent assertion on the rising clock edge,
// disabled while the active-low reset is asserted.
`ifndef BOUNDED_LIST_INSERT_DELETE_ASSERT_SVH
`define BOUNDED_LIST_INSERT_DELETE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounded list assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded list assertion failed");

`endif

// ===== rtl/bld_pkg.sv =====
`default_nettype none

package bld_pkg;

    localparam int CAPACITY    = 32;
    localparam int VALUE_WIDTH = 32;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam int OP_W        = 2;
    localparam int ARG_W       = 32;
    localparam int ELEM_W      = 32;
    localparam int IN_TDATA_W  = ((OP_W + ARG_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ELEM_W;
    localparam int OUT_TUSER_W = 2;

    // Bit positions inside the result tuser.
    localparam int TUSER_EMPTY   = 0;
    localparam int TUSER_DROPPED = 1;

    typedef logic [OP_W-1:0]        op_t;
    typedef logic [VALUE_WIDTH-1:0] value_t;

    localparam op_t OP_PUSH_FRONT = 2'd0;
    localparam op_t OP_PUSH_BACK  = 2'd1;
    localparam op_t OP_DELETE     = 2'd2;
    localparam op_t OP_NOP        = 2'd3;

    // What a cell loads at the next clock edge.
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_FROM_LEFT,
        CMD_FROM_RIGHT,
        CMD_LOAD,
        CMD_FROM_HEAD
    } cell_cmd_t;

    // Stored value: low VALUE_WIDTH bits of the sign-extended argument.
    function automatic value_t to_value(input logic [ARG_W-1:0] arg);
        logic [63:0] ext;
        ext = {{(64 - ARG_W){arg[ARG_W-1]}}, arg};
        return ext[VALUE_WIDTH-1:0];
    endfunction

    // Element field: low 32 bits of the sign-extended stored value.
    function automatic logic [ELEM_W-1:0] to_element(input value_t v);
        logic [63:0] ext;
        ext = {{(64 - VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
        return ext[ELEM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bounded_list_insert_delete.sv =====
// An accepted item passes through the update state, and its first result is then
// shown in the emit state. An item runs through accept, update and one result per
// element (an empty list gives one result); no new item is taken until its last
// result is out. The cell row rotates by one cell for each result taken.
// Reset (rst_n low, asynchronous) empties the list and returns to idle; cell contents
// are not cleared, as no cell beyond the element count is ever read.
`default_nettype none

module bounded_list_insert_delete (
    input  wire                               clk,
    input  wire                               rst_n,
    // Input items.
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata fields from bit 0: operation [1:0], argument [33:2], zero padding.
    input  wire  [bld_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Result items.
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // tdata fields from bit 0: element [31:0].
    output logic [bld_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tlast carries is_last.
    output logic                              m_axis_tlast,
    // tuser fields from bit 0: list_empty [0], insert_dropped [1].
    output logic [bld_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
    import bld_pkg::*;

    // The block works on one item at a time. In idle it takes an item; the update
    // state applies the operation to the whole cell row at once; the emit state
    // presents cell 0 and, each time a result is taken, rotates the occupied cells
    // left by one so that after count results the list is back in its order.
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_UPDATE = 3'b010,
        S_EMIT   = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic               dropped_reg, dropped_next;
    op_t                op_reg;
    logic [ARG_W-1:0]   arg_reg;

    cell_cmd_t          cell_cmd [CAPACITY];
    value_t             cell_val [CAPACITY];
    value_t             load_val;

    logic               in_fire;
    logic               out_fire;
    logic               is_insert;
    logic               is_full;
    logic               del_ok;
    logic [IDX_W-1:0]   del_pos;
    logic               list_empty;
    logic               last_result;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // Operation decode, used in the update state.
    assign is_insert = (op_reg == OP_PUSH_FRONT) || (op_reg == OP_PUSH_BACK);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    // A negative position or one at or past the count removes nothing.
    assign del_ok    = (op_reg == OP_DELETE) && !arg_reg[ARG_W-1]
                       && (arg_reg < ARG_W'(count_reg));
    assign del_pos   = arg_reg[IDX_W-1:0];
    assign load_val  = to_value(arg_reg);

    assign list_empty  = (count_reg == '0);
    assign last_result = list_empty || (remain_reg == CNT_W'(1));

    // Per-cell commands. Each cell compares its own index with the count or
    // the delete position, so the row does the whole shift at once.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_cmd[i] = CMD_HOLD;
            if (state_reg == S_UPDATE)
            begin
                if (is_insert && !is_full)
                begin
                    if (op_reg == OP_PUSH_FRONT)
                    begin
                        cell_cmd[i] = (i == 0) ? CMD_LOAD : CMD_FROM_LEFT;
                    end
                    else if (CNT_W'(i) == count_reg)
                    begin
                        cell_cmd[i] = CMD_LOAD;
                    end
                end
                else if (del_ok && (IDX_W'(i) >= del_pos))
                begin
                    cell_cmd[i] = CMD_FROM_RIGHT;
                end
            end
            else if ((state_reg == S_EMIT) && out_fire && !list_empty)
            begin
                // Rotate the occupied cells: the tail takes the head's value.
                if (CNT_W'(i + 1) == count_reg)
                begin
                    cell_cmd[i] = CMD_FROM_HEAD;
                end
                else if (CNT_W'(i) < count_reg)
                begin
                    cell_cmd[i] = CMD_FROM_RIGHT;
                end
            end
        end
    end

    // The cell row. Cell 0 is the front of the list.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        value_t left_val;
        value_t right_val;

        if (g == 0)
        begin : g_first
            assign left_val = load_val;
        end
        else
        begin : g_mid
            assign left_val = cell_val[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_val = cell_val[g];
        end
        else
        begin : g_inner
            assign right_val = cell_val[g+1];
        end

        bld_cell u_cell (
            .clk       (clk),
            .cmd       (cell_cmd[g]),
            .left_val  (left_val),
            .right_val (right_val),
            .head_val  (cell_val[0]),
            .load_val  (load_val),
            .value     (cell_val[g])
        );
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        remain_next  = remain_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                dropped_next = is_insert && is_full;
                if (is_insert && !is_full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else if (del_ok)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                remain_next = count_next;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_fire)
                begin
                    if (last_result)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        remain_next = remain_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            dropped_reg <= dropped_next;
        end
    end

    // The accepted item is held while it is applied.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= s_axis_tdata[OP_W-1:0];
            arg_reg <= s_axis_tdata[OP_W+ARG_W-1:OP_W];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_EMIT);

    // Results come straight from registers: cell 0 and the sequencer state.
    always_comb
    begin
        m_axis_tdata                = list_empty ? '0 : to_element(cell_val[0]);
        m_axis_tlast                = last_result;
        m_axis_tuser                = '0;
        m_axis_tuser[TUSER_EMPTY]   = list_empty;
        m_axis_tuser[TUSER_DROPPED] = dropped_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/bld_cell.sv =====
`default_nettype none

module bld_cell (
    input  wire                 clk,
    input  bld_pkg::cell_cmd_t  cmd,
    input  bld_pkg::value_t     left_val,
    input  bld_pkg::value_t     right_val,
    input  bld_pkg::value_t     head_val,
    input  bld_pkg::value_t     load_val,
    output bld_pkg::value_t     value
);
    import bld_pkg::*;

    value_t value_reg;
    value_t value_next;

    always_comb
    begin
        case (cmd)
            CMD_HOLD:       value_next = value_reg;
            CMD_FROM_LEFT:  value_next = left_val;
            CMD_FROM_RIGHT: value_next = right_val;
            CMD_LOAD:       value_next = load_val;
            CMD_FROM_HEAD:  value_next = head_val;
            default:        value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== rtl/bld_checker.sv =====
`default_nettype none
`include "bounded_list_insert_delete_assert.svh"

module bld_checker (
    input wire                             clk,
    input wire                             rst_n,
    input wire                             s_axis_tvalid,
    input wire                             s_axis_tready,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [bld_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire                             m_axis_tlast,
    input wire [bld_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
    import bld_pkg::*;

    logic in_fire;
    logic out_fire;
    logic stalled;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign stalled  = m_axis_tvalid && !m_axis_tready;

    // Only one item is in work: no input is taken while results are shown.
    `BLD_ASSERT_SAME(a_one_at_a_time, clk, rst_n, m_axis_tvalid, !s_axis_tready)

    // After an item is taken, the block stops taking items until its results are out.
    `BLD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !s_axis_tready)

    // An empty list gives a single zero result.
    `BLD_ASSERT_SAME(a_empty_single, clk, rst_n, m_axis_tvalid && m_axis_tuser[TUSER_EMPTY],
                     m_axis_tlast && (m_axis_tdata == '0))

    // Once the last result of an item is taken, nothing more is shown.
    `BLD_ASSERT_NEXT(a_last_ends, clk, rst_n, out_fire && m_axis_tlast, !m_axis_tvalid)

    // A stalled result holds.
    `BLD_ASSERT_NEXT(a_stall_hold, clk, rst_n, stalled,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
                     && $stable(m_axis_tuser))

endmodule

bind bounded_list_insert_delete bld_checker u_bld_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;

    import bld_pkg::*;

    // The watchdog ends the run after this many cycles in which neither side moves an item.
    localparam int STALL_LIMIT = 3000;

    // Cycles allowed after the last expected result.
    localparam int TAIL_CYCLES = 40;

    // One expected result item, as the block should present it on the result stream.
    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              last;
        logic              empty;
        logic              dropped;
    } list_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    wire  [OUT_TDATA_W-1:0] m_axis_tdata;
    wire                    m_axis_tlast;
    wire  [OUT_TUSER_W-1:0] m_axis_tuser;

    // Shadow copy of the list that the block should hold.
    value_t       shadow_cells [CAPACITY];
    int unsigned  shadow_count = 0;

    // Results still owed by the block, oldest first.
    list_result_t pending_results [$];

    int  mismatch_count = 0;
    bit  idle_on = 1'b1;
    int  ready_hold = 0;
    int  quiet_cycles = 0;

    bounded_list_insert_delete dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one accepted operation to the shadow list and queues every result item
    // that the block must then emit, front to back.
    task automatic apply_list_op(input op_t op, input logic [ARG_W-1:0] arg);
        logic signed [63:0] wide_arg;
        logic signed [63:0] wide_cell;
        value_t             cell_value;
        logic               dropped;
        list_result_t       item;
        wide_arg = signed'(arg);
        cell_value = wide_arg[VALUE_WIDTH-1:0];
        dropped = 1'b0;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
        begin
            if (shadow_count >= CAPACITY)
            begin
                // A full store refuses the insert and flags every result of this item.
                dropped = 1'b1;
            end
            else if (op == OP_PUSH_FRONT)
            begin
                for (int i = shadow_count; i > 0; i--)
                    shadow_cells[i] = shadow_cells[i-1];
                shadow_cells[0] = cell_value;
                shadow_count++;
            end
            else
            begin
                shadow_cells[shadow_count] = cell_value;
                shadow_count++;
            end
        end
        else if (op == OP_DELETE)
        begin
            // A negative position, or one at or past the count, removes nothing.
            if (!arg[ARG_W-1] && arg < shadow_count)
            begin
                for (int i = arg; i + 1 < shadow_count; i++)
                    shadow_cells[i] = shadow_cells[i+1];
                shadow_count--;
            end
        end
        if (shadow_count == 0)
        begin
            item.element = '0;
            item.last    = 1'b1;
            item.empty   = 1'b1;
            item.dropped = dropped;
            pending_results.push_back(item);
        end
        else
        begin
            for (int i = 0; i < shadow_count; i++)
            begin
                wide_cell    = signed'(shadow_cells[i]);
                item.element = wide_cell[ELEM_W-1:0];
                item.last    = (i + 1 == shadow_count);
                item.empty   = 1'b0;
                item.dropped = dropped;
                pending_results.push_back(item);
            end
        end
    endtask

    // Offers one input item, with an optional idle burst first, and returns at the
    // clock edge that accepts it. Every call starts and ends on a rising edge.
    task automatic send_op(input op_t op, input logic [ARG_W-1:0] arg);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[OP_W-1:0] = op;
        word[OP_W +: ARG_W] = arg;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_list_op(op, arg);
    endtask

    // Holds the input stream idle until the block has delivered every owed result.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Insert values lean toward the extremes of the signed range now and then.
    function automatic logic [ARG_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Delete positions are mostly valid; the rest are at the count, huge or negative.
    function automatic logic [ARG_W-1:0] pick_position();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r <= 6)
            return (shadow_count == 0) ? 32'd0 : $urandom_range(0, shadow_count - 1);
        else if (r == 7)
            return shadow_count;
        else if (r == 8)
            return $urandom;
        else
            return -$urandom_range(1, 5);
    endfunction

    // One random operation; push_weight out of ten picks an insert, one in ten a no-op.
    task automatic send_random_op(input int push_weight);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < push_weight)
            send_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
        else if (r < 9)
            send_op(OP_DELETE, pick_position());
        else
            send_op(OP_NOP, $urandom);
    endtask

    // Extremes of the value range, every operation, and deletes that must remove nothing.
    task automatic test_directed_edges();
        send_op(OP_NOP, 32'h0000_0000);
        send_op(OP_DELETE, 32'd0);
        send_op(OP_DELETE, 32'hFFFF_FFFF);
        send_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_op(OP_PUSH_BACK, 32'h8000_0000);
        send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(OP_PUSH_BACK, 32'h0000_0000);
        send_op(OP_PUSH_FRONT, 32'h0000_0001);
        send_op(OP_PUSH_BACK, 32'h5555_5555);
        send_op(OP_DELETE, shadow_count);
        send_op(OP_DELETE, 32'h7FFF_FFFF);
        send_op(OP_DELETE, 32'h8000_0000);
        send_op(OP_DELETE, 32'hFFFF_FFFF);
        send_op(OP_NOP, 32'hFFFF_FFFF);
        send_op(OP_DELETE, 32'd2);
        send_op(OP_DELETE, shadow_count - 1);
        send_op(OP_DELETE, 32'd0);
        while (shadow_count != 0)
            send_op(OP_DELETE, 32'd0);
        send_op(OP_DELETE, 32'd0);
        send_op(OP_PUSH_BACK, 32'h8000_0000);
        send_op(OP_DELETE, 32'd0);
    endtask

    // Fills the store to capacity, pushes into the full store, then empties it again.
    task automatic test_fill_and_overflow();
        while (shadow_count < CAPACITY)
            send_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
        repeat (4)
            send_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
        send_op(OP_NOP, $urandom);
        send_op(OP_DELETE, shadow_count);
        while (shadow_count != 0)
            send_op(OP_DELETE, pick_position());
    endtask

    // Random operations in segments that lean in turn toward growth and toward shrinking.
    task automatic test_random_mix(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_random_op(((i / 50) % 2 == 0) ? 6 : 3);
    endtask

    // The sender stops mid-run until the result stream has caught up completely.
    task automatic test_drain_pause();
        repeat (20)
            send_random_op(6);
        wait_for_drain();
        repeat (20)
            send_random_op(4);
    endtask

    // The last stretch runs with no idling on either side.
    task automatic test_back_to_back(input int n_items);
        idle_on <= 1'b0;
        for (int i = 0; i < n_items; i++)
            send_random_op(((i / 25) % 2 == 0) ? 7 : 3);
    endtask

    // The result side drops tready in random bursts while idling is on.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold    <= ready_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            ready_hold    <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        list_result_t seen;
        list_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.element = m_axis_tdata;
            seen.last    = m_axis_tlast;
            seen.empty   = m_axis_tuser[TUSER_EMPTY];
            seen.dropped = m_axis_tuser[TUSER_DROPPED];
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: element %h last %b empty %b dropped %b",
                             seen.element, seen.last, seen.empty, seen.dropped);
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen.element !== want.element || seen.last !== want.last ||
                    seen.empty !== want.empty || seen.dropped !== want.dropped)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $write("result mismatch: expected element %h last %b empty %b",
                               want.element, want.last, want.empty);
                        $display(" dropped %b, got element %h last %b empty %b dropped %b",
                                 want.dropped, seen.element, seen.last, seen.empty,
                                 seen.dropped);
                    end
                end
            end
        end
    end

    // Watchdog: a long stretch with no item moving on either side means the block hung.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_fill_and_overflow();
        test_random_mix(170);
        test_drain_pause();
        test_fill_and_overflow();
        test_back_to_back(100);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            mismatch_count++;

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/bld_pkg.sv
rtl/bld_cell.sv
rtl/bounded_list_insert_delete.sv
rtl/bld_checker.sv
bench/tb_top.sv
